// ===== rtl/bcg_pkg.sv =====
package bcg_pkg;

  typedef enum logic [5:0] {
    MODE_CHARGE     = 6'b000001,
    MODE_CHG_DIS    = 6'b000010,
    MODE_UNTIL      = 6'b000100,
    MODE_CHARGED    = 6'b001000,
    MODE_DISCH      = 6'b010000,
    MODE_DISCHARGED = 6'b100000
  } mode_t;

  localparam logic [2:0] CODE_CHARGE     = 3'd0;
  localparam logic [2:0] CODE_CHG_DIS    = 3'd1;
  localparam logic [2:0] CODE_UNTIL      = 3'd2;
  localparam logic [2:0] CODE_CHARGED    = 3'd3;
  localparam logic [2:0] CODE_DISCH      = 3'd4;
  localparam logic [2:0] CODE_DISCHARGED = 3'd5;

  localparam logic [2:0] REG_GUARD_ENABLE       = 3'd0;
  localparam logic [2:0] REG_CUTOFF_VOLTAGE     = 3'd1;
  localparam logic [2:0] REG_ABSORB_DV          = 3'd2;
  localparam logic [2:0] REG_FLOOR_DV           = 3'd3;
  localparam logic [2:0] REG_FULL_CHARGE_PERIOD = 3'd4;
  localparam logic [2:0] REG_START_STAMP        = 3'd5;

  localparam logic [10:0] NEAR_CUTOFF_MARGIN = 11'd50;
  localparam logic [10:0] CHARGED_HYST       = 11'd4;
  localparam logic signed [15:0] LOW_CHARGE_CA  = 16'sd40;
  localparam logic signed [15:0] HIGH_CHARGE_CA = 16'sd60;

  localparam logic        RST_GUARD_ENABLE       = 1'b1;
  localparam logic [9:0]  RST_CUTOFF_VOLTAGE     = 10'd584;
  localparam logic [9:0]  RST_ABSORB_DV          = 10'd512;
  localparam logic [9:0]  RST_FLOOR_DV           = 10'd420;
  localparam logic [31:0] RST_FULL_CHARGE_PERIOD = 32'd1209600;
  localparam logic [63:0] RST_START_STAMP        = 64'd0;

  typedef struct packed {
    logic        guard_enable;
    logic [9:0]  cutoff_voltage;
    logic [9:0]  absorb_dv;
    logic [9:0]  floor_dv;
    logic [31:0] full_charge_period;
  } cfg_t;

  typedef struct packed {
    logic [9:0]         voltage_dv;
    logic signed [15:0] current_ca;
    logic signed [15:0] target_current_ca;
    logic [63:0]        time_now;
    logic               time_valid;
  } item_t;

  typedef struct packed {
    mode_t              mode;
    logic [63:0]        clock_time;
    logic [63:0]        stamp;
    logic [9:0]         volt_min;
    logic [9:0]         volt_max;
    logic signed [15:0] curr_min;
    logic signed [15:0] curr_max;
  } gstate_t;

  typedef struct packed {
    logic [2:0]         guard_state;
    logic               state_changed;
    logic signed [15:0] limited_current_ca;
    logic               stamp_fix_valid;
    logic [63:0]        stamp_fix_time;
    logic               charged_save_valid;
    logic [63:0]        charged_save_time;
    logic [9:0]         voltage_low_mark;
    logic [9:0]         voltage_high_mark;
    logic signed [15:0] current_low_mark;
    logic signed [15:0] current_high_mark;
  } result_t;

  function automatic logic [2:0] mode_code(input mode_t m);
    logic [2:0] c;
    unique case (m)
      MODE_CHARGE:     c = CODE_CHARGE;
      MODE_CHG_DIS:    c = CODE_CHG_DIS;
      MODE_UNTIL:      c = CODE_UNTIL;
      MODE_CHARGED:    c = CODE_CHARGED;
      MODE_DISCH:      c = CODE_DISCH;
      MODE_DISCHARGED: c = CODE_DISCHARGED;
      default:         c = CODE_DISCHARGED;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/battery_charge_guard_fsm.sv =====
// An item accepted at a clock edge waits in the input register; when it moves on, its
// result is written into the output register and out_tvalid rises.
// Throughput: one item per cycle while out_tready stays high; a stalled result holds
// the input register, and in_tready falls once both registers are full.
// Reset (synchronous, rst_n low) restores register defaults, the discharged state,
// a zero clock time, the stored stamp from the start_stamp default and zero marks.
module battery_charge_guard_fsm (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // voltage_dv, current_ca, target_current_ca, time_now, time_valid, zero pad
  input  logic [111:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // guard_state, state_changed, limited_current_ca, stamp_fix_valid, stamp_fix_time,
  // charged_save_valid, charged_save_time, voltage_low_mark, voltage_high_mark,
  // current_low_mark, current_high_mark, zero pad
  output logic [207:0] out_tdata,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [5:0]   cfg_paddr,
  input  logic [63:0]  cfg_pwdata,
  output logic [63:0]  cfg_prdata,
  output logic         cfg_pready
);

  bcg_pkg::cfg_t    cfg_r;
  logic [63:0]      start_stamp_r;
  bcg_pkg::gstate_t st_r;
  bcg_pkg::gstate_t st_nxt;
  bcg_pkg::item_t   item_r;
  bcg_pkg::item_t   item_nxt;
  bcg_pkg::result_t res_nxt;
  bcg_pkg::result_t res_r;
  logic             s1_valid_r;
  logic             out_valid_r;
  logic             move;
  logic             cfg_wr;
  logic [2:0]       cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[5:3];

  assign move      = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || move;

  assign item_nxt.voltage_dv        = in_tdata[9:0];
  assign item_nxt.current_ca        = in_tdata[25:10];
  assign item_nxt.target_current_ca = in_tdata[41:26];
  assign item_nxt.time_now          = in_tdata[105:42];
  assign item_nxt.time_valid        = in_tdata[106];

  bcg_step u_step (
    .cfg    (cfg_r),
    .item   (item_r),
    .st     (st_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.guard_enable       <= bcg_pkg::RST_GUARD_ENABLE;
      cfg_r.cutoff_voltage     <= bcg_pkg::RST_CUTOFF_VOLTAGE;
      cfg_r.absorb_dv          <= bcg_pkg::RST_ABSORB_DV;
      cfg_r.floor_dv           <= bcg_pkg::RST_FLOOR_DV;
      cfg_r.full_charge_period <= bcg_pkg::RST_FULL_CHARGE_PERIOD;
      start_stamp_r            <= bcg_pkg::RST_START_STAMP;
      st_r.mode                <= bcg_pkg::MODE_DISCHARGED;
      st_r.clock_time          <= 64'd0;
      st_r.stamp               <= bcg_pkg::RST_START_STAMP;
      st_r.volt_min            <= 10'd0;
      st_r.volt_max            <= 10'd0;
      st_r.curr_min            <= 16'sd0;
      st_r.curr_max            <= 16'sd0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        bcg_pkg::REG_GUARD_ENABLE:       cfg_r.guard_enable       <= cfg_pwdata[0];
        bcg_pkg::REG_CUTOFF_VOLTAGE:     cfg_r.cutoff_voltage     <= cfg_pwdata[9:0];
        bcg_pkg::REG_ABSORB_DV:          cfg_r.absorb_dv          <= cfg_pwdata[9:0];
        bcg_pkg::REG_FLOOR_DV:           cfg_r.floor_dv           <= cfg_pwdata[9:0];
        bcg_pkg::REG_FULL_CHARGE_PERIOD: cfg_r.full_charge_period <= cfg_pwdata[31:0];
        bcg_pkg::REG_START_STAMP: begin
          start_stamp_r <= cfg_pwdata;
          st_r.stamp    <= cfg_pwdata;
        end
        default: begin
        end
      endcase
    end else if (move) begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    unique case (cfg_idx)
      bcg_pkg::REG_GUARD_ENABLE:       cfg_prdata = {63'd0, cfg_r.guard_enable};
      bcg_pkg::REG_CUTOFF_VOLTAGE:     cfg_prdata = {54'd0, cfg_r.cutoff_voltage};
      bcg_pkg::REG_ABSORB_DV:          cfg_prdata = {54'd0, cfg_r.absorb_dv};
      bcg_pkg::REG_FLOOR_DV:           cfg_prdata = {54'd0, cfg_r.floor_dv};
      bcg_pkg::REG_FULL_CHARGE_PERIOD: cfg_prdata = {32'd0, cfg_r.full_charge_period};
      bcg_pkg::REG_START_STAMP:        cfg_prdata = start_stamp_r;
      default:                         cfg_prdata = 64'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        s1_valid_r <= 1'b1;
      end else if (move) begin
        s1_valid_r <= 1'b0;
      end
      if (move) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= item_nxt;
    end
    if (move) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0,
                       res_r.current_high_mark,
                       res_r.current_low_mark,
                       res_r.voltage_high_mark,
                       res_r.voltage_low_mark,
                       res_r.charged_save_time,
                       res_r.charged_save_valid,
                       res_r.stamp_fix_time,
                       res_r.stamp_fix_valid,
                       res_r.limited_current_ca,
                       res_r.state_changed,
                       res_r.guard_state};

  a_mode_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !move |=> $stable(st_r.mode))
    else $error("guard state changed without an item moving to the result register");

  a_save_to_disch: assert property (@(posedge clk) disable iff (!rst_n)
    (move && res_nxt.charged_save_valid) |=> (st_r.mode == bcg_pkg::MODE_DISCH))
    else $error("charged save without a move to discharge");

  a_zero_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (res_r.guard_state == bcg_pkg::CODE_UNTIL ||
                     res_r.guard_state == bcg_pkg::CODE_DISCHARGED))
    |-> (res_r.limited_current_ca == 16'sd0))
    else $error("feed-in current not blocked in a no-feed state");

endmodule

// ===== rtl/bcg_step.sv =====
module bcg_step (
  input  bcg_pkg::cfg_t    cfg,
  input  bcg_pkg::item_t   item,
  input  bcg_pkg::gstate_t st,
  output bcg_pkg::gstate_t st_nxt,
  output bcg_pkg::result_t res
);

  logic [63:0] diff_now;
  logic [63:0] diff_old;
  logic [63:0] fix_stamp;
  logic [63:0] clock_new;
  logic        fix;
  logic        aged;
  logic [10:0] volt11;
  logic [10:0] cutoff11;
  logic [10:0] absorb11;
  logic [10:0] disch11;
  logic        near_cutoff;
  logic        below_hyst;
  logic        vseed;
  logic        cseed;
  logic [9:0]  vmin0;
  logic [9:0]  vmax0;
  logic signed [15:0] cmin0;
  logic signed [15:0] cmax0;
  bcg_pkg::mode_t mode_n;
  logic [63:0] stamp_n;
  logic        save;
  logic signed [15:0] limited;

  assign diff_now  = item.time_now - st.stamp;
  assign diff_old  = st.clock_time - st.stamp;
  assign fix_stamp = item.time_now - {33'd0, cfg.full_charge_period[31:1]};
  assign fix       = item.time_valid && (diff_now > {31'd0, cfg.full_charge_period, 1'b0});
  assign clock_new = item.time_valid ? item.time_now : st.clock_time;

  // A freshly replaced stamp sits half a period back, so it never counts as aged.
  always_comb begin
    if (fix) begin
      aged = 1'b0;
    end else if (item.time_valid) begin
      aged = diff_now > {32'd0, cfg.full_charge_period};
    end else begin
      aged = diff_old > {32'd0, cfg.full_charge_period};
    end
  end

  assign volt11      = {1'b0, item.voltage_dv};
  assign cutoff11    = {1'b0, cfg.cutoff_voltage};
  assign absorb11    = {1'b0, cfg.absorb_dv};
  assign disch11     = {1'b0, cfg.floor_dv};
  assign near_cutoff = (volt11 + bcg_pkg::NEAR_CUTOFF_MARGIN) >= cutoff11;
  assign below_hyst  = (volt11 + bcg_pkg::CHARGED_HYST) < cutoff11;

  assign vseed = (st.volt_min == 10'd0) && (st.volt_max == 10'd0);
  assign cseed = (st.curr_min == 16'sd0) && (st.curr_max == 16'sd0);
  assign vmin0 = vseed ? item.voltage_dv : st.volt_min;
  assign vmax0 = vseed ? item.voltage_dv : st.volt_max;
  assign cmin0 = cseed ? item.current_ca : st.curr_min;
  assign cmax0 = cseed ? item.current_ca : st.curr_max;

  always_comb begin
    mode_n  = st.mode;
    stamp_n = fix ? fix_stamp : st.stamp;
    save    = 1'b0;
    if (cfg.guard_enable) begin
      unique case (st.mode)
        bcg_pkg::MODE_CHG_DIS: begin
          if (volt11 <= absorb11) begin
            mode_n = bcg_pkg::MODE_CHARGE;
          end else if (volt11 >= cutoff11) begin
            mode_n = bcg_pkg::MODE_CHARGED;
          end
        end
        bcg_pkg::MODE_CHARGE: begin
          if (near_cutoff) begin
            mode_n = bcg_pkg::MODE_CHG_DIS;
          end else if ((clock_new != 64'd0) && aged) begin
            mode_n = bcg_pkg::MODE_UNTIL;
          end else if (item.current_ca < bcg_pkg::LOW_CHARGE_CA) begin
            mode_n = bcg_pkg::MODE_DISCH;
          end
        end
        bcg_pkg::MODE_UNTIL: begin
          if (volt11 >= cutoff11) begin
            mode_n = bcg_pkg::MODE_CHARGED;
          end
        end
        bcg_pkg::MODE_CHARGED: begin
          stamp_n = clock_new;
          if (below_hyst) begin
            save   = 1'b1;
            mode_n = bcg_pkg::MODE_DISCH;
          end
        end
        bcg_pkg::MODE_DISCH: begin
          if (volt11 <= disch11) begin
            mode_n = bcg_pkg::MODE_DISCHARGED;
          end else if (item.current_ca > bcg_pkg::HIGH_CHARGE_CA) begin
            mode_n = bcg_pkg::MODE_CHARGE;
          end
        end
        bcg_pkg::MODE_DISCHARGED: begin
          if (volt11 > absorb11) begin
            mode_n = bcg_pkg::MODE_CHARGE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (mode_n)
      bcg_pkg::MODE_CHARGE: begin
        limited = (item.target_current_ca > item.current_ca) ? item.current_ca
                                                             : item.target_current_ca;
      end
      bcg_pkg::MODE_UNTIL, bcg_pkg::MODE_DISCHARGED: begin
        limited = 16'sd0;
      end
      default: begin
        limited = item.target_current_ca;
      end
    endcase
  end

  always_comb begin
    st_nxt.mode       = mode_n;
    st_nxt.clock_time = clock_new;
    st_nxt.stamp      = stamp_n;
    st_nxt.volt_min   = (item.voltage_dv < vmin0) ? item.voltage_dv : vmin0;
    st_nxt.volt_max   = (item.voltage_dv > vmax0) ? item.voltage_dv : vmax0;
    st_nxt.curr_min   = (item.current_ca < cmin0) ? item.current_ca : cmin0;
    st_nxt.curr_max   = (item.current_ca > cmax0) ? item.current_ca : cmax0;

    res.guard_state        = bcg_pkg::mode_code(mode_n);
    res.state_changed      = cfg.guard_enable && (mode_n != st.mode);
    res.limited_current_ca = limited;
    res.stamp_fix_valid    = fix;
    res.stamp_fix_time     = fix ? fix_stamp : 64'd0;
    res.charged_save_valid = save;
    res.charged_save_time  = save ? clock_new : 64'd0;
    res.voltage_low_mark   = st_nxt.volt_min;
    res.voltage_high_mark  = st_nxt.volt_max;
    res.current_low_mark   = st_nxt.curr_min;
    res.current_high_mark  = st_nxt.curr_max;
  end

endmodule
